// File: hw/rtl/irpdt_pkg.sv
// Shared types and constants of the IR pulse-distance transmitter.
package irpdt_pkg;

  localparam int TPU_W    = 7;
  localparam int DELAY_W  = 16;
  localparam int PERIOD_W = 20;
  localparam int US_W     = 14;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BITPOS_W = 4;

  localparam logic [US_W-1:0] US_LEADER_MARK  = 14'd9000;
  localparam logic [US_W-1:0] US_LEADER_SPACE = 14'd4500;
  localparam logic [US_W-1:0] US_SHORT        = 14'd560;
  localparam logic [US_W-1:0] US_LONG         = 14'd1600;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 20'hFFFFF;

  localparam logic [TPU_W-1:0]   TPU_RESET   = 7'd6;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd8000;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_START  = 2'd1,
    KIND_EXPIRY = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_US = 2'd0,
    CFG_START_DELAY  = 2'd1
  } cfg_reg_t;

  // Segment that the next expiry produces.
  typedef enum logic [2:0] {
    PH_LEADER    = 3'd0,
    PH_GAP       = 3'd1,
    PH_BIT_MARK  = 3'd2,
    PH_BIT_SPACE = 3'd4,
    PH_FINISH    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [TPU_W-1:0]   ticks_per_us;
    logic [DELAY_W-1:0] start_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic                carrier_on;
    logic [PERIOD_W-1:0] period_ticks;
    logic                timer_running;
    logic                frame_done;
  } res_t;

endpackage

// File: hw/rtl/ir_pulse_distance_transmitter.sv
// Top level of the NEC-style IR pulse-distance frame sequencer.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   kind, byte_index, byte_value, byte_count
//   out_     output     out_valid / out_ready carrier_on, period_ticks, timer_running,
//                                             frame_done
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every input item is handled in one cycle: its result, if any, is in the result
// register on the following cycle, and a new item may be taken at every clock edge.
// Each item takes a single pass through the sequencer logic, a 7 by 14 bit
// scaling multiply and the registered read port of the message store.
// Reset (synchronous, active low) idles the sequencer and restores the register
// defaults; the message store is not cleared and holds nothing until loaded.
// A stalled result sits in the result register, a second one in the skid stage,
// and input transfers pause only while both are occupied.
module ir_pulse_distance_transmitter #(
  parameter int MAX_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [irpdt_pkg::KIND_W-1:0]     in_kind,
  input  logic [irpdt_pkg::IDX_W-1:0]      in_byte_index,
  input  logic [irpdt_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic [irpdt_pkg::COUNT_W-1:0]    in_byte_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_carrier_on,
  output logic [irpdt_pkg::PERIOD_W-1:0]   out_period_ticks,
  output logic                             out_timer_running,
  output logic                             out_frame_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [irpdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpdt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irpdt_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic in_transfer;
  logic res_valid;
  res_t res, out_res;

  // The configuration registers are always ready; a write to an index beyond the
  // register list completes but changes nothing.
  assign cfg_ready   = 1'b1;
  assign in_transfer = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_TICKS_PER_US: cfg_nxt.ticks_per_us      = cfg_data[TPU_W-1:0];
        CFG_START_DELAY:  cfg_nxt.start_delay_ticks = cfg_data[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_us      <= TPU_RESET;
      cfg_r.start_delay_ticks <= DELAY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The sequencer works on the item in the cycle of its transfer; its state
  // registers and the store update at that same edge.
  irpdt_seq #(
    .MAX_BYTES(MAX_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_transfer),
    .kind       (in_kind),
    .byte_index (in_byte_index),
    .byte_value (in_byte_value),
    .byte_count (in_byte_count),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Results are registered here, with a skid stage so that input transfers
  // carry on while the output side stalls, until the skid stage fills too.
  irpdt_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_res   (res),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_carrier_on    = out_res.carrier_on;
  assign out_period_ticks  = out_res.period_ticks;
  assign out_timer_running = out_res.timer_running;
  assign out_frame_done    = out_res.frame_done;

endmodule

// File: hw/rtl/irpdt_seq.sv
// Frame sequencer of the IR transmitter: message store, frame state and segment lengths.
module irpdt_seq #(
  parameter int MAX_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  logic [irpdt_pkg::KIND_W-1:0]  kind,
  input  logic [irpdt_pkg::IDX_W-1:0]   byte_index,
  input  logic [irpdt_pkg::BYTE_W-1:0]  byte_value,
  input  logic [irpdt_pkg::COUNT_W-1:0] byte_count,
  input  irpdt_pkg::cfg_t               cfg,
  output logic                          res_valid,
  output irpdt_pkg::res_t               res
);
  import irpdt_pkg::*;

  localparam int AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW   = $clog2(MAX_BYTES + 1);
  localparam int CMPW = AW + 1;

  logic [BYTE_W-1:0] store_mem [MAX_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  phase_t              phase_r, phase_nxt;
  logic [BITPOS_W-1:0] bit_position_r, bit_position_nxt;
  logic [AW-1:0]       byte_position_r, byte_position_nxt;
  logic [CW-1:0]       bytes_to_send_r, bytes_to_send_nxt;
  logic                sending_r, sending_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [CMPW-1:0] next_byte;
  logic [2:0]      bit_sel;
  logic            bit_one;
  logic [US_W-1:0] seg_us;
  logic [TPU_W+US_W-1:0] product;
  logic            use_scaled;

  assign next_byte = {1'b0, byte_position_r} + CMPW'(1);
  assign bit_sel   = 3'd7 - bit_position_r[2:0];
  assign bit_one   = rd_data_r[bit_sel];
  assign product   = (TPU_W+US_W)'(cfg.ticks_per_us) * (TPU_W+US_W)'(seg_us);

  always_comb begin
    phase_nxt         = phase_r;
    bit_position_nxt  = bit_position_r;
    byte_position_nxt = byte_position_r;
    bytes_to_send_nxt = bytes_to_send_r;
    sending_nxt       = sending_r;
    wr_en             = 1'b0;
    wr_addr           = AW'(byte_index);
    rd_en             = 1'b0;
    rd_addr           = byte_position_r;
    res_valid         = 1'b0;
    seg_us            = US_SHORT;
    use_scaled        = 1'b1;
    res.carrier_on    = 1'b0;
    res.timer_running = 1'b1;
    res.frame_done    = 1'b0;
    if (item_valid) begin
      case (kind)
        KIND_LOAD: begin
          wr_en = ((IDX_W+2)'(byte_index) < (IDX_W+2)'(MAX_BYTES));
        end
        KIND_START: begin
          if ({1'b0, byte_count} > (COUNT_W+1)'(MAX_BYTES)) begin
            bytes_to_send_nxt = CW'(MAX_BYTES);
          end else begin
            bytes_to_send_nxt = CW'(byte_count);
          end
          sending_nxt = 1'b1;
          res_valid   = 1'b1;
          use_scaled  = 1'b0;
        end
        KIND_EXPIRY: begin
          if (sending_r) begin
            case (phase_r)
              PH_LEADER: begin
                res_valid      = 1'b1;
                res.carrier_on = 1'b1;
                seg_us         = US_LEADER_MARK;
                phase_nxt      = PH_GAP;
              end
              PH_GAP: begin
                res_valid = 1'b1;
                seg_us    = US_LEADER_SPACE;
                phase_nxt = PH_BIT_MARK;
              end
              PH_BIT_MARK: begin
                res_valid      = 1'b1;
                res.carrier_on = 1'b1;
                phase_nxt      = PH_BIT_SPACE;
                rd_en          = 1'b1;
                if (bit_position_r >= BITPOS_W'(8)) begin
                  bit_position_nxt = '0;
                  if (next_byte >= CMPW'(bytes_to_send_r)) begin
                    // Last byte sent: this mark is the stop mark.
                    byte_position_nxt = '0;
                    phase_nxt         = PH_FINISH;
                    rd_en             = 1'b0;
                  end else begin
                    byte_position_nxt = AW'(next_byte);
                    rd_addr           = AW'(next_byte);
                  end
                end
              end
              PH_BIT_SPACE: begin
                res_valid        = 1'b1;
                seg_us           = bit_one ? US_LONG : US_SHORT;
                bit_position_nxt = bit_position_r + BITPOS_W'(1);
                phase_nxt        = PH_BIT_MARK;
              end
              PH_FINISH: begin
                res_valid         = 1'b1;
                use_scaled        = 1'b0;
                res.timer_running = 1'b0;
                res.frame_done    = 1'b1;
                phase_nxt         = PH_LEADER;
                sending_nxt       = 1'b0;
              end
              default: begin
                phase_nxt = PH_LEADER;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
    if (!use_scaled) begin
      res.period_ticks = res.frame_done ? '0 : PERIOD_W'(cfg.start_delay_ticks);
    end else if (product > (TPU_W+US_W)'(PERIOD_MAX)) begin
      res.period_ticks = PERIOD_MAX;
    end else begin
      res.period_ticks = product[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= byte_value;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_LEADER;
      bit_position_r  <= '0;
      byte_position_r <= '0;
      bytes_to_send_r <= '0;
      sending_r       <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      bit_position_r  <= bit_position_nxt;
      byte_position_r <= byte_position_nxt;
      bytes_to_send_r <= bytes_to_send_nxt;
      sending_r       <= sending_nxt;
    end
  end

  a_idle_at_leader: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> phase_r == PH_LEADER)
    else $error("phase left the leader while no frame is being sent");

  a_bit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_position_r <= BITPOS_W'(8))
    else $error("bit position ran past the end of a byte");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_done) |=> (!sending_r && byte_position_r == '0))
    else $error("frame end did not return the sequencer to idle");

endmodule

// File: hw/rtl/irpdt_outbuf.sv
// Two-entry result register with skid stage for the IR transmitter.
module irpdt_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  irpdt_pkg::res_t push_res,
  output logic            can_accept,
  output logic            out_valid,
  input  logic            out_ready,
  output irpdt_pkg::res_t out_res
);
  import irpdt_pkg::*;

  res_t main_r, skid_r;
  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic pop;

  assign pop        = main_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_res    = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_valid_nxt = 1'b1;
      end else begin
        main_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      main_r <= skid_r;
    end else if (push && (pop || !main_valid_r)) begin
      main_r <= push_res;
    end
    if (push && main_valid_r && !pop) begin
      skid_r <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid stage holds a result while the result register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("result pushed while both stages are full");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skid_valid_r) |=> (main_valid_r && main_r == $past(skid_r)))
    else $error("skid result lost on hand-over");

endmodule

// File: bench/tb_ir_pulse_distance_transmitter.sv
// Self-checking testbench for the IR pulse-distance frame sequencer, with its own frame predictor.
module tb_ir_pulse_distance_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  import irpdt_pkg::*;

  // Store depth given to the block. Every entry is preloaded before the first frame,
  // so no frame ever reads a byte that was never written.
  localparam int STORE_DEPTH = 32;
  // Share of cycles in which either side holds back, in percent.
  localparam int IDLE_PCT = 18;
  // Cycles without any transfer after which the run is declared hung. A correct run
  // never goes quiet for more than a short random stall or a settling pause.
  localparam int QUIET_LIMIT = 2000;
  // Pause after the last expected result before a register write or the end.
  localparam int SETTLE_CYCLES = 4;
  // Expiries that are always enough to run out any frame once a start with a byte
  // count of zero or one has been given: leader, gap, eight bit pairs, stop, end.
  localparam int RESYNC_EXPIRIES = 20;
  // Random items per register setting.
  localparam int ITEMS_PER_SETTING = 90;
  localparam int MAX_PRINTED = 40;

  // Kind and register index codes that the block must ignore.
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   idx;
    logic [BYTE_W-1:0]  val;
    logic [COUNT_W-1:0] cnt;
  } ir_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [IDX_W-1:0]      in_byte_index = '0;
  logic [BYTE_W-1:0]     in_byte_value = '0;
  logic [COUNT_W-1:0]    in_byte_count = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_carrier_on;
  logic [PERIOD_W-1:0]   out_period_ticks;
  logic                  out_timer_running;
  logic                  out_frame_done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Items waiting to be driven, and segments the block still owes us.
  ir_item_t pending_items[$];
  res_t     segment_q[$];

  int unsigned items_queued = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          no_gaps = 1'b0;

  // Predictor copy of the register file.
  logic [TPU_W-1:0]   tpu_now   = TPU_RESET;
  logic [DELAY_W-1:0] delay_now = DELAY_RESET;

  // Predictor copy of the sequencer state.
  logic [2:0]         seq_phase = PH_LEADER;
  logic [BITPOS_W-1:0] bit_pos  = '0;
  int unsigned        byte_pos = 0;
  int unsigned        bytes_to_send = 0;
  logic               bit_is_one = 1'b0;
  logic               sending = 1'b0;
  logic [BYTE_W-1:0]  msg_bytes [STORE_DEPTH];

  ir_pulse_distance_transmitter #(.MAX_BYTES(STORE_DEPTH)) dut (.*);

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Segment length in ticks, saturating at the widest period the port can carry.
  function automatic logic [PERIOD_W-1:0] seg_ticks(int unsigned us);
    longint unsigned t;
    t = longint'(tpu_now) * us;
    return (t > PERIOD_MAX) ? PERIOD_MAX : t[PERIOD_W-1:0];
  endfunction

  function automatic void owe_segment(logic carrier, logic [PERIOD_W-1:0] ticks,
                                      logic running, logic done);
    res_t r;
    r.carrier_on    = carrier;
    r.period_ticks  = ticks;
    r.timer_running = running;
    r.frame_done    = done;
    segment_q.push_back(r);
  endfunction

  // Advances the predicted sequencer by one accepted item.
  function automatic void sequence_item(ir_item_t it);
    logic        ended;
    logic [7:0]  b;
    int unsigned n;
    ended = 1'b0;
    case (it.kind)
      KIND_LOAD: begin
        if (it.idx < STORE_DEPTH) msg_bytes[it.idx] = it.val;
      end
      KIND_START: begin
        // A start re-arms the timer but keeps the bit and byte position.
        n = (it.cnt > STORE_DEPTH) ? STORE_DEPTH : it.cnt;
        bytes_to_send = n;
        sending = 1'b1;
        owe_segment(1'b0, PERIOD_W'(delay_now), 1'b1, 1'b0);
      end
      KIND_EXPIRY: begin
        if (sending) begin
          case (seq_phase)
            PH_LEADER: begin
              owe_segment(1'b1, seg_ticks(US_LEADER_MARK), 1'b1, 1'b0);
              seq_phase = PH_GAP;
            end
            PH_GAP: begin
              owe_segment(1'b0, seg_ticks(US_LEADER_SPACE), 1'b1, 1'b0);
              seq_phase = PH_BIT_MARK;
            end
            PH_BIT_MARK: begin
              // The byte count is checked only after a whole byte has gone out,
              // which is why a count of zero still sends the first byte.
              if (bit_pos >= 8) begin
                bit_pos = '0;
                byte_pos++;
                if (byte_pos >= bytes_to_send) begin
                  byte_pos = 0;
                  owe_segment(1'b1, seg_ticks(US_SHORT), 1'b1, 1'b0);
                  seq_phase = PH_FINISH;
                  ended = 1'b1;
                end
              end
              if (!ended) begin
                b = (byte_pos < STORE_DEPTH) ? msg_bytes[byte_pos] : '0;
                bit_is_one = b[3'd7 - bit_pos[2:0]];
                owe_segment(1'b1, seg_ticks(US_SHORT), 1'b1, 1'b0);
                seq_phase = PH_BIT_SPACE;
              end
            end
            PH_BIT_SPACE: begin
              owe_segment(1'b0, seg_ticks(bit_is_one ? US_LONG : US_SHORT), 1'b1, 1'b0);
              bit_pos = bit_pos + BITPOS_W'(1);
              seq_phase = PH_BIT_MARK;
            end
            PH_FINISH: begin
              owe_segment(1'b0, '0, 1'b0, 1'b1);
              seq_phase = PH_LEADER;
              sending = 1'b0;
            end
            default: seq_phase = PH_LEADER;
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued items on the input channel, holding each one steady
  // until its transfer, and feeds every accepted item to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    ir_item_t cur;
    ir_item_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        cur.kind = in_kind;
        cur.idx  = in_byte_index;
        cur.val  = in_byte_value;
        cur.cnt  = in_byte_count;
        sequence_item(cur);
      end
      // The slot is free once the item on the port has been taken, or if none was.
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_items.pop_front();
          in_valid      <= 1'b1;
          in_kind       <= nxt.kind;
          in_byte_index <= nxt.idx;
          in_byte_value <= nxt.val;
          in_byte_count <= nxt.cnt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results with random back-pressure and checks each transfer,
  // field by field, against the oldest segment still owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (segment_q.size() == 0) begin
          note_mismatch("result transfer with no segment expected");
        end else begin
          want = segment_q.pop_front();
          if (out_carrier_on !== want.carrier_on)
            note_mismatch($sformatf("carrier_on %b, expected %b",
                                    out_carrier_on, want.carrier_on));
          if (out_period_ticks !== want.period_ticks)
            note_mismatch($sformatf("period_ticks %0d, expected %0d",
                                    out_period_ticks, want.period_ticks));
          if (out_timer_running !== want.timer_running)
            note_mismatch($sformatf("timer_running %b, expected %b",
                                    out_timer_running, want.timer_running));
          if (out_frame_done !== want.frame_done)
            note_mismatch($sformatf("frame_done %b, expected %b",
                                    out_frame_done, want.frame_done));
        end
      end
      out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_ir_pulse_distance_transmitter NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fields that an item kind does not use carry random values; the block must
  // ignore them.
  function automatic ir_item_t blank_item(logic [KIND_W-1:0] k);
    ir_item_t it;
    it.kind = k;
    it.idx  = IDX_W'($urandom);
    it.val  = BYTE_W'($urandom);
    it.cnt  = COUNT_W'($urandom);
    return it;
  endfunction

  function automatic void queue_load(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    ir_item_t it;
    it = blank_item(KIND_LOAD);
    it.idx = idx;
    it.val = val;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_start(logic [COUNT_W-1:0] cnt);
    ir_item_t it;
    it = blank_item(KIND_START);
    it.cnt = cnt;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  // Timer expiries, optionally with message loads slipped in between them.
  function automatic void queue_expiries(int unsigned n, bit with_loads);
    for (int unsigned i = 0; i < n; i++) begin
      if (with_loads && $urandom_range(0, 9) == 0)
        queue_load(IDX_W'($urandom), BYTE_W'($urandom));
      pending_items.push_back(blank_item(KIND_EXPIRY));
      items_queued++;
    end
  endfunction

  // Expiries that one clean frame takes from start to its idle result.
  function automatic int unsigned frame_expiries(logic [COUNT_W-1:0] cnt);
    int unsigned n;
    n = (cnt == 0) ? 1 : ((cnt > STORE_DEPTH) ? STORE_DEPTH : cnt);
    return 4 + 16 * n;
  endfunction

  // Mostly short frames; now and then an empty count or a long, possibly
  // saturating one.
  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return COUNT_W'($urandom_range(5, (1 << COUNT_W) - 1));
    if (r < 14) return '0;
    return COUNT_W'($urandom_range(1, 4));
  endfunction

  // A full frame, or a broken one that restarts mid-frame and is then run out so
  // that the next frame begins from a clean sequencer.
  function automatic void queue_frame(logic [COUNT_W-1:0] cnt, bit broken);
    queue_start(cnt);
    if (!broken) begin
      queue_expiries(frame_expiries(cnt), 1'b1);
    end else begin
      queue_expiries($urandom_range(0, frame_expiries(cnt) - 1), 1'b1);
      if ($urandom_range(0, 1)) pending_items.push_back(blank_item(KIND_UNUSED));
      if ($urandom_range(0, 1)) begin
        queue_start(pick_count());
        queue_expiries($urandom_range(0, 40), 1'b1);
      end
      queue_start(COUNT_W'($urandom_range(0, 1)));
      queue_expiries(RESYNC_EXPIRIES, 1'b0);
    end
  endfunction

  // Items between frames: loads, expiries while idle and the unused kind.
  function automatic void queue_noise();
    case ($urandom_range(0, 2))
      0: queue_load(IDX_W'($urandom), BYTE_W'($urandom));
      1: pending_items.push_back(blank_item(KIND_EXPIRY));
      default: pending_items.push_back(blank_item(KIND_UNUSED));
    endcase
  endfunction

  task automatic run_random(int unsigned n);
    int unsigned first;
    int unsigned r;
    first = items_queued;
    while (items_queued - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_frame(pick_count(), 1'b0);
      else if (r < 85) queue_frame(pick_count(), 1'b1);
      else repeat ($urandom_range(1, 3)) queue_noise();
    end
  endtask

  // Returns once every queued item has been taken, every owed segment has
  // arrived and the block has had time to settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || segment_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the predictor takes the new value at the transfer.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_TICKS_PER_US) tpu_now = data[TPU_W-1:0];
    else if (idx == CFG_START_DELAY) delay_now = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int unsigned tpu_plan [5] = '{1, 127, 0, 64, 0};
  int unsigned delay_plan [5] = '{1, 65535, 0, 0, 0};

  initial begin
    logic [CFG_DATA_W-1:0] word;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Preload the whole store; the first bytes carry the pattern extremes.
    queue_load(IDX_W'(0), 8'hA5);
    queue_load(IDX_W'(1), 8'h00);
    queue_load(IDX_W'(2), 8'hFF);
    queue_load(IDX_W'(3), 8'h80);
    queue_load(IDX_W'(4), 8'h01);
    for (int i = 5; i < STORE_DEPTH; i++) queue_load(IDX_W'(i), BYTE_W'($urandom));

    // Directed part at the reset settings: an expiry while idle and the unused
    // kind are both ignored, then one full single-byte frame, and an expiry after
    // the frame has finished.
    pending_items.push_back(blank_item(KIND_EXPIRY));
    pending_items.push_back(blank_item(KIND_UNUSED));
    queue_start(COUNT_W'(1));
    queue_expiries(frame_expiries(COUNT_W'(1)), 1'b0);
    pending_items.push_back(blank_item(KIND_EXPIRY));
    wait_idle();

    run_random(ITEMS_PER_SETTING);
    wait_idle();

    // Further settings: smallest, saturating, zero, mid-range rate, random.
    tpu_plan[4]   = $urandom_range(1, 64);
    delay_plan[3] = $urandom_range(1, 65535);
    delay_plan[4] = $urandom_range(1, 65535);
    for (int p = 0; p < 5; p++) begin
      // Upper data bits are junk for the seven-bit register and must be dropped.
      word = CFG_DATA_W'($urandom);
      word[TPU_W-1:0] = TPU_W'(tpu_plan[p]);
      write_reg(CFG_TICKS_PER_US, word);
      write_reg(CFG_START_DELAY, CFG_DATA_W'(delay_plan[p]));
      if (p == 2) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));

      // One setting runs with neither side ever holding back.
      no_gaps = (p == 1);
      if (p == 0) queue_frame('0, 1'b0);
      if (p == 3) queue_frame('1, 1'b0);
      run_random(ITEMS_PER_SETTING);
      wait_idle();
    end
    no_gaps = 1'b0;

    repeat (8) @(posedge clk);
    if (segment_q.size() != 0)
      note_mismatch($sformatf("%0d segments never arrived", segment_q.size()));
    if (mismatches == 0) begin
      $display("tb_ir_pulse_distance_transmitter OK");
    end else begin
      $display("tb_ir_pulse_distance_transmitter NOT OK");
    end
    $finish;
  end

endmodule

// File: ir_pulse_distance_transmitter.f
hw/rtl/irpdt_pkg.sv
hw/rtl/irpdt_seq.sv
hw/rtl/irpdt_outbuf.sv
hw/rtl/ir_pulse_distance_transmitter.sv
bench/tb_ir_pulse_distance_transmitter.sv
